FILE: src/mce_pkg.sv
// ----------------------------------------------------------------------------
// mce_pkg
// Types, symbol codes and the Morse pattern table shared by the encoder.
// ----------------------------------------------------------------------------
package mce_pkg;

  localparam int unsigned MaxPat     = 8;
  localparam int unsigned PatLenW    = 4;
  localparam int unsigned SymW       = 2;
  localparam logic [7:0]  CaseOffset = 8'd32;
  localparam logic [7:0]  LowerA     = 8'h61;
  localparam logic [7:0]  LowerZ     = 8'h7a;

  typedef enum logic [SymW-1:0] {
    SymDot   = 2'd0,
    SymDash  = 2'd1,
    SymSlash = 2'd2,
    SymSep   = 2'd3
  } sym_e;

  // Pattern of one character: a word-slash flag, its length and a dash mask, bit 0 sent first.
  typedef struct packed {
    logic               slash;
    logic [PatLenW-1:0] len;
    logic [MaxPat-1:0]  dash;
  } pat_t;

  // One queued job for the back end: optional separator, then len symbols.
  typedef struct packed {
    logic                   sep;
    logic [PatLenW-1:0]     len;
    logic [MaxPat*SymW-1:0] syms;
  } cmd_t;

  function automatic pat_t mk(input logic [PatLenW-1:0] len, input logic [MaxPat-1:0] dash);
    pat_t p;
    p.slash = 1'b0;
    p.len   = len;
    p.dash  = dash;
    return p;
  endfunction

  function automatic pat_t pattern_of(input logic [7:0] ch);
    pat_t p;
    p = mk(4'd0, 8'b0);
    case (ch)
      8'h41: p = mk(4'd2, 8'b10);
      8'h42: p = mk(4'd4, 8'b0001);
      8'h43: p = mk(4'd4, 8'b0101);
      8'h44: p = mk(4'd3, 8'b001);
      8'h45: p = mk(4'd1, 8'b0);
      8'h46: p = mk(4'd4, 8'b0100);
      8'h47: p = mk(4'd3, 8'b011);
      8'h48: p = mk(4'd4, 8'b0000);
      8'h49: p = mk(4'd2, 8'b00);
      8'h4a: p = mk(4'd4, 8'b1110);
      8'h4b: p = mk(4'd3, 8'b101);
      8'h4c: p = mk(4'd4, 8'b0010);
      8'h4d: p = mk(4'd2, 8'b11);
      8'h4e: p = mk(4'd2, 8'b01);
      8'h4f: p = mk(4'd3, 8'b111);
      8'h50: p = mk(4'd4, 8'b0110);
      8'h51: p = mk(4'd4, 8'b1011);
      8'h52: p = mk(4'd3, 8'b010);
      8'h53: p = mk(4'd3, 8'b000);
      8'h54: p = mk(4'd1, 8'b1);
      8'h55: p = mk(4'd3, 8'b100);
      8'h56: p = mk(4'd4, 8'b1000);
      8'h57: p = mk(4'd3, 8'b110);
      8'h58: p = mk(4'd4, 8'b1001);
      8'h59: p = mk(4'd4, 8'b1101);
      8'h5a: p = mk(4'd4, 8'b0011);
      8'h30: p = mk(4'd5, 8'b11111);
      8'h31: p = mk(4'd5, 8'b11110);
      8'h32: p = mk(4'd5, 8'b11100);
      8'h33: p = mk(4'd5, 8'b11000);
      8'h34: p = mk(4'd5, 8'b10000);
      8'h35: p = mk(4'd5, 8'b00000);
      8'h36: p = mk(4'd5, 8'b00001);
      8'h37: p = mk(4'd5, 8'b00011);
      8'h38: p = mk(4'd5, 8'b00111);
      8'h39: p = mk(4'd5, 8'b01111);
      8'h2e: p = mk(4'd6, 8'b101010);
      8'h2c: p = mk(4'd6, 8'b110011);
      8'h3f: p = mk(4'd6, 8'b001100);
      8'h27: p = mk(4'd6, 8'b011110);
      8'h21: p = mk(4'd6, 8'b110101);
      8'h2f: p = mk(4'd5, 8'b01001);
      8'h28: p = mk(4'd5, 8'b01101);
      8'h29: p = mk(4'd6, 8'b101101);
      8'h26: p = mk(4'd5, 8'b00010);
      8'h3a: p = mk(4'd6, 8'b000111);
      8'h3b: p = mk(4'd6, 8'b010101);
      8'h3d: p = mk(4'd5, 8'b10001);
      8'h2b: p = mk(4'd5, 8'b01010);
      8'h2d: p = mk(4'd6, 8'b100001);
      8'h5f: p = mk(4'd6, 8'b101100);
      8'h22: p = mk(4'd6, 8'b010010);
      8'h24: p = mk(4'd7, 8'b1001000);
      8'h40: p = mk(4'd6, 8'b010110);
      8'h23: p = mk(4'd8, 8'b00000000);
      8'h20: begin
        p       = mk(4'd1, 8'b0);
        p.slash = 1'b1;
      end
      default: p = mk(4'd0, 8'b0);
    endcase
    return p;
  endfunction

endpackage

FILE: src/morse_char_encoder_top.sv
// ----------------------------------------------------------------------------
// morse_char_encoder_top
// International Morse code encoder, one ASCII character in, symbol beats out.
// ----------------------------------------------------------------------------
// Each accepted character becomes a run of symbol beats: a separator first
// (except for the first character since reset), then the dots and dashes of
// its pattern, or a word slash for a space; the final beat of a character
// carries last. The output side sends one beat per cycle while out_ready_i is
// high, and a character has from 1 up to 9 beats, the most for '#'; that
// serializer sets the sustained rate. The input side takes a character in any
// cycle in which the job queue of QueueDepth entries has room, so characters
// can be accepted while earlier ones are still being sent. An unknown first
// character is accepted and produces no beats.
module morse_char_encoder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] char_code_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [1:0] symbol_o,
  output logic       last_o
);

  logic          push, full, pop, q_valid;
  mce_pkg::cmd_t cmd_in, cmd_out;

  mce_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .char_code_i (char_code_i),
    .push_o      (push),
    .cmd_o       (cmd_in),
    .full_i      (full)
  );

  mce_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (cmd_out)
  );

  mce_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (cmd_out),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .symbol_o    (symbol_o),
    .last_o      (last_o)
  );

endmodule

FILE: src/mce_front.sv
// ----------------------------------------------------------------------------
// mce_front
// Accepts characters, folds case, looks up the pattern and queues a job.
// ----------------------------------------------------------------------------
module mce_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    char_code_i,
  output logic          push_o,
  output mce_pkg::cmd_t cmd_o,
  input  logic          full_i
);

  logic          at_start_q, at_start_d;
  logic          accept;
  logic [7:0]    ch;
  mce_pkg::pat_t pat;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  always_comb begin
    ch = char_code_i;
    if (char_code_i >= mce_pkg::LowerA && char_code_i <= mce_pkg::LowerZ) begin
      ch = char_code_i - mce_pkg::CaseOffset;
    end
    pat = mce_pkg::pattern_of(ch);
  end

  always_comb begin
    cmd_o.sep = !at_start_q;
    cmd_o.len = pat.len;
    for (int i = 0; i < mce_pkg::MaxPat; i++) begin
      if (pat.slash) begin
        cmd_o.syms[i*mce_pkg::SymW +: mce_pkg::SymW] = mce_pkg::SymSlash;
      end else if (pat.dash[i]) begin
        cmd_o.syms[i*mce_pkg::SymW +: mce_pkg::SymW] = mce_pkg::SymDash;
      end else begin
        cmd_o.syms[i*mce_pkg::SymW +: mce_pkg::SymW] = mce_pkg::SymDot;
      end
    end
  end

  // An unknown first character produces no symbols, so nothing is queued.
  assign push_o = accept && (pat.len != '0 || !at_start_q);

  always_comb begin
    at_start_d = at_start_q;
    if (accept) begin
      at_start_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
    end else begin
      at_start_q <= at_start_d;
    end
  end

endmodule

FILE: src/mce_fifo.sv
// ----------------------------------------------------------------------------
// mce_fifo
// Short job queue between the front and back ends.
// ----------------------------------------------------------------------------
module mce_fifo #(
  parameter int unsigned Depth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  mce_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output mce_pkg::cmd_t cmd_o
);

  localparam int unsigned IdxW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  mce_pkg::cmd_t   mem_q [Depth];
  logic [IdxW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign full_o  = (cnt_q == Full);
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == LastIdx) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == LastIdx) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

FILE: src/mce_back.sv
// ----------------------------------------------------------------------------
// mce_back
// Serializes one queued job into symbol beats, one beat per cycle while out_ready_i is high.
// ----------------------------------------------------------------------------
module mce_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  mce_pkg::cmd_t cmd_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output logic [1:0]    symbol_o,
  output logic          last_o
);

  logic                                     busy_q, busy_d;
  logic                                     sep_q, sep_d;
  logic [mce_pkg::PatLenW-1:0]              cnt_q, cnt_d;
  logic [mce_pkg::MaxPat*mce_pkg::SymW-1:0] syms_q, syms_d;
  logic                                     take, last_sym;

  assign last_sym    = sep_q ? (cnt_q == '0) : (cnt_q == mce_pkg::PatLenW'(1));
  assign take        = busy_q && out_ready_i;
  // The next job loads in the cycle the final beat leaves, so jobs run gap-free.
  assign pop_o       = q_valid_i && (!busy_q || (take && last_sym));
  assign out_valid_o = busy_q;
  assign symbol_o    = sep_q ? mce_pkg::SymSep : syms_q[mce_pkg::SymW-1:0];
  assign last_o      = last_sym;

  always_comb begin
    busy_d = busy_q;
    sep_d  = sep_q;
    cnt_d  = cnt_q;
    syms_d = syms_q;
    if (take) begin
      if (sep_q) begin
        sep_d = 1'b0;
      end else begin
        syms_d = syms_q >> mce_pkg::SymW;
        cnt_d  = cnt_q - 1'b1;
      end
      if (last_sym) begin
        busy_d = 1'b0;
      end
    end
    if (pop_o) begin
      busy_d = 1'b1;
      sep_d  = cmd_i.sep;
      cnt_d  = cmd_i.len;
      syms_d = cmd_i.syms;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    syms_q <= syms_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      sep_q  <= 1'b0;
    end else begin
      busy_q <= busy_d;
      sep_q  <= sep_d;
    end
  end

endmodule

FILE: src/mce_checker.sv
// ----------------------------------------------------------------------------
// mce_checker
// Port-level checks on the encoder's output stream.
// ----------------------------------------------------------------------------
module mce_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] symbol_o,
  input logic       last_o
);

  logic out_beat;
  logic sep_open_q;

  assign out_beat = out_valid_o && out_ready_i;

  // Set while the last beat sent was a separator that did not end its character.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sep_open_q <= 1'b0;
    end else if (out_beat) begin
      sep_open_q <= (symbol_o == mce_pkg::SymSep) && !last_o;
    end
  end

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out_valid_o dropped before the beat was taken");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(symbol_o) && $stable(last_o))
    else $error("output payload changed while stalled");

  a_slash_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && symbol_o == mce_pkg::SymSlash |-> last_o)
    else $error("word slash not marked as last beat");

  a_no_double_sep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_beat && sep_open_q |-> symbol_o != mce_pkg::SymSep)
    else $error("separator followed by another separator");

endmodule

bind morse_char_encoder_top mce_checker u_mce_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .symbol_o    (symbol_o),
  .last_o      (last_o)
);

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the Morse character encoder.
// ----------------------------------------------------------------------------
// Characters are sent on the input channel and every accepted one is turned
// into its expected run of symbol beats by a predictor held in a small
// scoreboard class. Each output beat is checked in order against the oldest
// expected beat. A directed set of characters comes first, then random text
// mixed with arbitrary bytes, with random stalls on both channels.
// ----------------------------------------------------------------------------

typedef struct {
  mce_pkg::sym_e symbol;
  logic          last;
} morse_beat_t;

class morse_beat_checker;
  morse_beat_t expected_beats[$];
  bit          at_start = 1'b1;
  int          errors   = 0;

  // Dots, dashes and the word slash of one upper case character.
  function string morse_pattern(logic [7:0] c);
    case (c)
      "A": return ".-";      "B": return "-...";    "C": return "-.-.";
      "D": return "-..";     "E": return ".";       "F": return "..-.";
      "G": return "--.";     "H": return "....";    "I": return "..";
      "J": return ".---";    "K": return "-.-";     "L": return ".-..";
      "M": return "--";      "N": return "-.";      "O": return "---";
      "P": return ".--.";    "Q": return "--.-";    "R": return ".-.";
      "S": return "...";     "T": return "-";       "U": return "..-";
      "V": return "...-";    "W": return ".--";     "X": return "-..-";
      "Y": return "-.--";    "Z": return "--..";
      "0": return "-----";   "1": return ".----";   "2": return "..---";
      "3": return "...--";   "4": return "....-";   "5": return ".....";
      "6": return "-....";   "7": return "--...";   "8": return "---..";
      "9": return "----.";
      ".": return ".-.-.-";  ",": return "--..--";  "?": return "..--..";
      "'": return ".----.";  "!": return "-.-.--";  "/": return "-..-.";
      "(": return "-.--.";   ")": return "-.--.-";  "&": return ".-...";
      ":": return "---...";  ";": return "-.-.-.";  "=": return "-...-";
      "+": return ".-.-.";   "-": return "-....-";  "_": return "..--.-";
      "\"": return ".-..-."; "$": return "...-..-"; "@": return ".--.-.";
      "#": return "........";
      " ": return "/";
      default: return "";
    endcase
  endfunction

  function void note_char(logic [7:0] code);
    logic [7:0]  c;
    string       pat;
    int          total;
    int          k;
    morse_beat_t b;
    c = code;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    pat   = morse_pattern(c);
    total = pat.len() + (at_start ? 0 : 1);
    k     = 0;
    if (!at_start) begin
      b.symbol = mce_pkg::SymSep;
      b.last   = (k == total - 1);
      expected_beats.push_back(b);
      k++;
    end
    at_start = 1'b0;
    for (int i = 0; i < pat.len(); i++) begin
      if (pat[i] == "-") b.symbol = mce_pkg::SymDash;
      else if (pat[i] == "/") b.symbol = mce_pkg::SymSlash;
      else b.symbol = mce_pkg::SymDot;
      b.last = (k == total - 1);
      expected_beats.push_back(b);
      k++;
    end
  endfunction

  function void check_beat(logic [1:0] symbol, logic last);
    morse_beat_t b;
    if (expected_beats.size() == 0) begin
      $error("unexpected beat: symbol %0d last %0d", symbol, last);
      errors++;
      return;
    end
    b = expected_beats.pop_front();
    if (symbol !== b.symbol) begin
      $error("symbol: expected %0d, actual %0d", b.symbol, symbol);
      errors++;
    end
    if (last !== b.last) begin
      $error("last: expected %0d, actual %0d", b.last, last);
      errors++;
    end
  endfunction

  function int pending();
    return expected_beats.size();
  endfunction
endclass

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  logic       in_ready_o;
  logic [7:0] char_code_i = 8'h00;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [1:0] symbol_o;
  logic       last_o;

  morse_beat_checker beat_chk = new();

  bit    in_calm  = 1'b0;
  bit    out_calm = 1'b0;
  string known_chars =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789.,?'!/()&:;=+-_\"$@#";

  logic [7:0] directed_chars[] = '{
    8'hff, "A", "z", "a", "Z", "#", " ", "0", "9", "$", "@", 8'h00, 8'h80,
    8'h7f, 8'h60, "{", "[", 8'he1, ".", ",", "?", "'", "!", "\"", " "
  };

  morse_char_encoder_top dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .char_code_i(char_code_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .symbol_o   (symbol_o),
    .last_o     (last_o)
  );

  always #6 clk_i = ~clk_i;

  // Both channels are observed in one place so that a character accepted at
  // the same edge as a beat is always predicted first.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) beat_chk.note_char(char_code_i);
      if (out_valid_o && out_ready_i) beat_chk.check_beat(symbol_o, last_o);
    end
  end

  task automatic send_char(input logic [7:0] c);
    int gap;
    gap = in_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    char_code_i <= c;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // The extra edge lets the monitor note the character accepted just before.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (beat_chk.pending() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return known_chars[$urandom_range(0, known_chars.len() - 1)];
    if (r == 7) return " ";
    return 8'($urandom_range(0, 255));
  endfunction

  // Output side: a random stall before each beat, with calm stretches.
  initial begin
    int gap;
    while (!rst_ni) @(posedge clk_i);
    forever begin
      gap = out_calm ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_chars[i]) send_char(directed_chars[i]);
    wait_drained();

    for (int n = 0; n < 310; n++) begin
      if (n % 40 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
      // Hold the sender back once until the encoder has gone quiet.
      if (n == 150) wait_drained();
      send_char(pick_char());
    end

    wait_drained();
    repeat (30) @(posedge clk_i);
    if (beat_chk.errors == 0 && beat_chk.pending() == 0) begin
      $display("PASS morse_char_encoder_top");
    end else begin
      $display("FAIL morse_char_encoder_top");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL morse_char_encoder_top");
    $finish;
  end

endmodule
